@@ rtl/fca_pkg.sv @@
// ---------------------------------------------------------------------------
// fca_pkg
// Shared types, constants and helpers of the filtered column aggregate block.
// ---------------------------------------------------------------------------
package fca_pkg;

  localparam int VALUE_W  = 48;
  localparam int COLUMN_W = 4;
  localparam int SELECT_W = 7;
  localparam int CODE_W   = 3;
  localparam int PCOUNT_W = 2;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 64;
  localparam int INDEX_W  = 3;

  localparam int NUM_COLUMNS          = 12;
  localparam int NUM_PREDICATES_DEF   = 3;
  localparam int REG_PREDS            = 3;
  localparam int QUEUE_DEPTH          = 4;
  localparam int DIV_STEPS            = SUM_W;
  localparam int STEP_W               = $clog2(DIV_STEPS);

  localparam logic [COLUMN_W-1:0] AGG_COLUMN_RESET = 4'd9;

  localparam logic signed [VALUE_W-1:0] MAX48 = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] MIN48 = {1'b1, {(VALUE_W-1){1'b0}}};

  // input item kinds
  localparam logic OP_CELL = 1'b0;
  localparam logic OP_END  = 1'b1;

  // compare codes
  localparam logic [CODE_W-1:0] CMP_EQ = 3'd0;
  localparam logic [CODE_W-1:0] CMP_NE = 3'd1;
  localparam logic [CODE_W-1:0] CMP_GE = 3'd2;
  localparam logic [CODE_W-1:0] CMP_LE = 3'd3;
  localparam logic [CODE_W-1:0] CMP_GT = 3'd4;
  localparam logic [CODE_W-1:0] CMP_LT = 3'd5;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_AGG_COLUMN   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_PRED_COUNT   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_PRED0_SELECT = 3'd2;

  // work handed from the front to the back
  typedef struct packed {
    logic                      emit;   // end of table: report and clear
    logic signed [VALUE_W-1:0] value;  // aggregate value of a passing row
  } entry_t;

  typedef struct packed {
    logic                      no_match;
    logic [COUNT_W-1:0]        match_count;
    logic signed [VALUE_W-1:0] avg_value;
    logic signed [VALUE_W-1:0] smallest;
    logic signed [VALUE_W-1:0] largest;
  } result_t;

  function automatic logic compare_ok(input logic [CODE_W-1:0] code,
                                      input logic signed [VALUE_W-1:0] a,
                                      input logic signed [VALUE_W-1:0] refv);
    logic ok;
    case (code)
      CMP_EQ:  ok = (a == refv);
      CMP_NE:  ok = (a != refv);
      CMP_GE:  ok = (a >= refv);
      CMP_LE:  ok = (a <= refv);
      CMP_GT:  ok = (a > refv);
      CMP_LT:  ok = (a < refv);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/filtered_column_aggregate_unit.sv @@
// ---------------------------------------------------------------------------
// filtered_column_aggregate_unit
// Filters table rows by up to three column predicates and reports max, min,
// average and count of one column over the passing rows at end of table.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         one table cell or an end-of-table marker per item
//  m_*       out        one report per end-of-table marker
//  cfg_*     in         register writes, one per cycle, no read-back
//
//  Cells are taken one per cycle while the four-entry queue between the
//  front and the back has room; the back folds one passing row per cycle
//  while it is not busy with an end-of-table item, which occupies the back
//  to load, to run the bit-serial divider (skipped for a zero count) and
//  to load the output register. Reset is synchronous and needs no clearing pass.
//  A stalled output holds the back; a full queue holds the input.
// ---------------------------------------------------------------------------
module filtered_column_aggregate_unit #(
  parameter int NUM_PREDICATES = fca_pkg::NUM_PREDICATES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [fca_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [fca_pkg::VALUE_W-1:0]  cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [55:0]                  s_tdata,   // column[3:0], cell_value[51:4]
  input  logic [1:0]                   s_tuser,   // op[0], cell_empty[1]
  input  logic                         s_tlast,   // row_last
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [167:0]                 m_tdata    // largest[47:0], smallest[95:48],
                                                  // avg_value[143:96],
                                                  // match_count[159:144], no_match[160]
);

  logic             push;
  fca_pkg::entry_t  push_entry;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  fca_pkg::entry_t  q_entry;
  fca_pkg::result_t result;

  fca_front #(
    .NUM_PREDICATES(NUM_PREDICATES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser[0]),
    .in_column  (s_tdata[3:0]),
    .in_value   (s_tdata[51:4]),
    .in_empty   (s_tuser[1]),
    .in_last    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  fca_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .valid      (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  fca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {7'b0000000, result.no_match, result.match_count, result.avg_value,
                    result.smallest, result.largest};

endmodule

@@ rtl/fca_front.sv @@
// ---------------------------------------------------------------------------
// fca_front
// Holds configuration, tests each cell against the predicates, tracks the
// open row and queues passing rows and end-of-table requests.
// ---------------------------------------------------------------------------
module fca_front #(
  parameter int NUM_PREDICATES = fca_pkg::NUM_PREDICATES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [fca_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [fca_pkg::VALUE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [fca_pkg::COLUMN_W-1:0]        in_column,
  input  logic signed [fca_pkg::VALUE_W-1:0]  in_value,
  input  logic                                in_empty,
  input  logic                                in_last,
  input  logic                                q_full,
  output logic                                push,
  output fca_pkg::entry_t                     push_entry
);

  localparam int PredSlots = (NUM_PREDICATES < fca_pkg::REG_PREDS) ?
                             NUM_PREDICATES : fca_pkg::REG_PREDS;

  logic [fca_pkg::COLUMN_W-1:0]       agg_column;
  logic [fca_pkg::PCOUNT_W-1:0]       pred_count;
  logic [fca_pkg::SELECT_W-1:0]       pred_select    [PredSlots];
  logic signed [fca_pkg::VALUE_W-1:0] pred_reference [PredSlots];

  logic                               row_passing;
  logic signed [fca_pkg::VALUE_W-1:0] row_agg_value;
  logic                               row_agg_present;

  logic                               accept;
  logic                               col_ok;
  logic                               fail_any;
  logic                               agg_hit;
  logic                               passing_cell;
  logic signed [fca_pkg::VALUE_W-1:0] agg_value_cell;
  logic                               present_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      agg_column <= fca_pkg::AGG_COLUMN_RESET;
      pred_count <= '0;
      for (int k = 0; k < PredSlots; k++) begin
        pred_select[k]    <= '0;
        pred_reference[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == fca_pkg::REG_AGG_COLUMN) begin
        agg_column <= cfg_data[fca_pkg::COLUMN_W-1:0];
      end
      if (cfg_index == fca_pkg::REG_PRED_COUNT) begin
        pred_count <= cfg_data[fca_pkg::PCOUNT_W-1:0];
      end
      for (int k = 0; k < PredSlots; k++) begin
        if (cfg_index == fca_pkg::INDEX_W'(fca_pkg::REG_PRED0_SELECT + 2 * k)) begin
          pred_select[k] <= cfg_data[fca_pkg::SELECT_W-1:0];
        end
        if (cfg_index == fca_pkg::INDEX_W'(fca_pkg::REG_PRED0_SELECT + 2 * k + 1)) begin
          pred_reference[k] <= cfg_data;
        end
      end
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign col_ok   = {3'b000, in_column} < 7'(fca_pkg::NUM_COLUMNS);

  // a predicate on a cell of its column fails the row on an empty cell too
  always_comb begin
    fail_any = 1'b0;
    for (int k = 0; k < PredSlots; k++) begin
      if ((fca_pkg::PCOUNT_W'(k) < pred_count) &&
          (pred_select[k][fca_pkg::SELECT_W-1:fca_pkg::CODE_W] == in_column) &&
          (in_empty || !fca_pkg::compare_ok(pred_select[k][fca_pkg::CODE_W-1:0],
                                            in_value, pred_reference[k]))) begin
        fail_any = 1'b1;
      end
    end
  end

  assign agg_hit        = col_ok && (in_column == agg_column);
  assign passing_cell   = row_passing && !(col_ok && fail_any);
  assign agg_value_cell = agg_hit ? in_value : row_agg_value;
  assign present_cell   = agg_hit ? !in_empty : row_agg_present;

  assign push = accept && ((in_op == fca_pkg::OP_END) ||
                           (in_last && passing_cell && present_cell));
  assign push_entry.emit  = (in_op == fca_pkg::OP_END);
  assign push_entry.value = agg_value_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_passing     <= 1'b1;
      row_agg_value   <= '0;
      row_agg_present <= 1'b0;
    end else if (accept) begin
      // close or drop the row on its last cell or at end of table
      if ((in_op == fca_pkg::OP_END) || in_last) begin
        row_passing     <= 1'b1;
        row_agg_value   <= '0;
        row_agg_present <= 1'b0;
      end else begin
        row_passing     <= passing_cell;
        row_agg_value   <= agg_value_cell;
        row_agg_present <= present_cell;
      end
    end
  end

endmodule

@@ rtl/fca_queue.sv @@
// ---------------------------------------------------------------------------
// fca_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module fca_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fca_pkg::entry_t push_entry,
  output logic            full,
  output logic            valid,
  input  logic            pop,
  output fca_pkg::entry_t pop_entry
);

  localparam int PtrW  = $clog2(fca_pkg::QUEUE_DEPTH);
  localparam int FillW = $clog2(fca_pkg::QUEUE_DEPTH + 1);

  fca_pkg::entry_t  slots [fca_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full      = (fill == FillW'(fca_pkg::QUEUE_DEPTH));
  assign valid     = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/fca_back.sv @@
// ---------------------------------------------------------------------------
// fca_back
// Folds passing rows into the running totals and, at end of table, divides
// the sum by the count one quotient bit per cycle and reports the result.
// ---------------------------------------------------------------------------
module fca_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  fca_pkg::entry_t  q_entry,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output fca_pkg::result_t result
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    FINISH
  } state_t;

  state_t                             state;
  logic signed [fca_pkg::VALUE_W-1:0] running_max;
  logic signed [fca_pkg::VALUE_W-1:0] running_min;
  logic signed [fca_pkg::SUM_W-1:0]   running_sum;
  logic [fca_pkg::COUNT_W-1:0]        running_count;

  logic [fca_pkg::SUM_W-1:0]          quo;
  logic [fca_pkg::COUNT_W-1:0]        rem;
  logic [fca_pkg::COUNT_W-1:0]        divisor;
  logic                               neg;
  logic [fca_pkg::STEP_W-1:0]         step;

  logic signed [fca_pkg::SUM_W:0]     sum_wide;
  logic signed [fca_pkg::SUM_W-1:0]   sum_next;
  logic [fca_pkg::COUNT_W:0]          rem_shift;
  logic                               rem_ge;
  logic [fca_pkg::COUNT_W:0]          rem_sub;
  logic [fca_pkg::SUM_W-1:0]          quo_neg;
  logic signed [fca_pkg::VALUE_W-1:0] avg_sat;
  logic                               res_load;

  assign q_pop = (state == IDLE) && q_valid;

  // load the output register once it is free
  assign res_load = (state == FINISH) && (!res_valid || res_ready);

  // saturating add of the row value to the sum
  assign sum_wide = {running_sum[fca_pkg::SUM_W-1], running_sum} +
                    (fca_pkg::SUM_W + 1)'(q_entry.value);
  always_comb begin
    if (sum_wide[fca_pkg::SUM_W] != sum_wide[fca_pkg::SUM_W-1]) begin
      sum_next = sum_wide[fca_pkg::SUM_W] ? {1'b1, {(fca_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(fca_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[fca_pkg::SUM_W-1:0];
    end
  end

  // restoring division step on the magnitude
  assign rem_shift = {rem, quo[fca_pkg::SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign rem_sub   = rem_shift - {1'b0, divisor};

  // sign and clamp the quotient to the value range
  assign quo_neg = -quo;
  always_comb begin
    if (!neg) begin
      avg_sat = (quo > fca_pkg::SUM_W'(fca_pkg::MAX48)) ? fca_pkg::MAX48
                                                        : quo[fca_pkg::VALUE_W-1:0];
    end else begin
      avg_sat = (quo > (fca_pkg::SUM_W'(1) << (fca_pkg::VALUE_W - 1))) ? fca_pkg::MIN48
                                                        : quo_neg[fca_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      res_valid     <= 1'b0;
      running_max   <= fca_pkg::MIN48;
      running_min   <= fca_pkg::MAX48;
      running_sum   <= '0;
      running_count <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (q_valid) begin
            if (q_entry.emit) begin
              neg     <= running_sum[fca_pkg::SUM_W-1] && (running_count != '0);
              quo     <= (running_count == '0) ? '0 :
                         (running_sum[fca_pkg::SUM_W-1] ? -running_sum : running_sum);
              rem     <= '0;
              divisor <= running_count;
              step    <= fca_pkg::STEP_W'(fca_pkg::DIV_STEPS - 1);
              state   <= (running_count == '0) ? FINISH : DIVIDE;
            end else begin
              if (q_entry.value > running_max) begin
                running_max <= q_entry.value;
              end
              if (q_entry.value < running_min) begin
                running_min <= q_entry.value;
              end
              running_sum <= sum_next;
              if (running_count != {fca_pkg::COUNT_W{1'b1}}) begin
                running_count <= running_count + 1'b1;
              end
            end
          end
        end
        DIVIDE: begin
          rem <= rem_ge ? rem_sub[fca_pkg::COUNT_W-1:0] : rem_shift[fca_pkg::COUNT_W-1:0];
          quo <= {quo[fca_pkg::SUM_W-2:0], rem_ge};
          if (step == '0) begin
            state <= FINISH;
          end else begin
            step <= step - 1'b1;
          end
        end
        FINISH: begin
          // hold until the output register is free
          if (res_load) begin
            result.largest     <= running_max;
            result.smallest    <= running_min;
            result.avg_value   <= avg_sat;
            result.match_count <= running_count;
            result.no_match    <= (running_count == '0);
            running_max        <= fca_pkg::MIN48;
            running_min        <= fca_pkg::MAX48;
            running_sum        <= '0;
            running_count      <= '0;
            state              <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/fca_report_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fca_report_checker
// Watches the register port and both streams of the filtered column
// aggregate unit, folds every accepted cell into its own model of the row
// filter and totals, and compares each report with the oldest one predicted.
// ---------------------------------------------------------------------------
module fca_report_checker #(
  parameter int NUM_PRED = fca_pkg::NUM_PREDICATES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [fca_pkg::INDEX_W-1:0] cfg_index,
  input  logic [fca_pkg::VALUE_W-1:0] cfg_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [55:0]                 s_tdata,   // column[3:0], cell_value[51:4]
  input  logic [1:0]                  s_tuser,   // op[0], cell_empty[1]
  input  logic                        s_tlast,   // row_last
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [167:0]                m_tdata,   // largest[47:0], smallest[95:48],
                                                 // avg_value[143:96],
                                                 // match_count[159:144], no_match[160]
  output int                          mismatches,
  output int                          reports_due
);

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // register copy
  logic [fca_pkg::COLUMN_W-1:0]       agg_col;
  logic [fca_pkg::PCOUNT_W-1:0]       pred_cnt;
  logic [fca_pkg::SELECT_W-1:0]       pred_sel [fca_pkg::REG_PREDS];
  logic signed [fca_pkg::VALUE_W-1:0] pred_ref [fca_pkg::REG_PREDS];

  // row and table totals
  bit                                 row_pass;
  logic signed [fca_pkg::VALUE_W-1:0] row_agg;
  bit                                 row_agg_ok;
  logic signed [fca_pkg::VALUE_W-1:0] run_max;
  logic signed [fca_pkg::VALUE_W-1:0] run_min;
  longint                             run_sum;
  logic [fca_pkg::COUNT_W-1:0]        run_cnt;

  fca_pkg::result_t due_reports [$];
  int               err_count = 0;

  assign mismatches = err_count;

  function automatic bit test_passes(input logic [fca_pkg::CODE_W-1:0] code,
                                     input logic signed [fca_pkg::VALUE_W-1:0] a,
                                     input logic signed [fca_pkg::VALUE_W-1:0] b);
    case (code)
      fca_pkg::CMP_EQ: return a == b;
      fca_pkg::CMP_NE: return a != b;
      fca_pkg::CMP_GE: return a >= b;
      fca_pkg::CMP_LE: return a <= b;
      fca_pkg::CMP_GT: return a > b;
      fca_pkg::CMP_LT: return a < b;
      default:         return 1'b1;
    endcase
  endfunction

  task automatic open_row();
    row_pass   = 1'b1;
    row_agg    = '0;
    row_agg_ok = 1'b0;
  endtask

  task automatic clear_totals();
    run_max = fca_pkg::MIN48;
    run_min = fca_pkg::MAX48;
    run_sum = 0;
    run_cnt = '0;
  endtask

  task automatic close_row();
    longint v;
    v = longint'(row_agg);
    if (row_pass && row_agg_ok) begin
      if (row_agg > run_max) run_max = row_agg;
      if (row_agg < run_min) run_min = row_agg;
      if (v > 0 && run_sum > SUM_MAX - v) run_sum = SUM_MAX;
      else if (v < 0 && run_sum < SUM_MIN - v) run_sum = SUM_MIN;
      else run_sum = run_sum + v;
      if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
    end
    open_row();
  endtask

  task automatic issue_report();
    fca_pkg::result_t r;
    longint           q;
    q = 0;
    if (run_cnt != '0) begin
      q = run_sum / longint'(run_cnt);
      if (q > longint'(fca_pkg::MAX48)) q = longint'(fca_pkg::MAX48);
      if (q < longint'(fca_pkg::MIN48)) q = longint'(fca_pkg::MIN48);
    end
    r.largest     = run_max;
    r.smallest    = run_min;
    r.avg_value   = q[fca_pkg::VALUE_W-1:0];
    r.match_count = run_cnt;
    r.no_match    = (run_cnt == '0);
    due_reports.push_back(r);
    open_row();
    clear_totals();
  endtask

  task automatic take_cell();
    logic [fca_pkg::COLUMN_W-1:0]       col;
    logic signed [fca_pkg::VALUE_W-1:0] val;
    logic                               empty;
    logic [fca_pkg::COLUMN_W-1:0]       pcol;
    int                                 limit;
    col   = s_tdata[3:0];
    val   = s_tdata[51:4];
    empty = s_tuser[1];
    if (s_tuser[0] == fca_pkg::OP_END) begin
      issue_report();
      return;
    end
    if (col < fca_pkg::NUM_COLUMNS) begin
      limit = pred_cnt;
      if (limit > NUM_PRED) limit = NUM_PRED;
      if (limit > fca_pkg::REG_PREDS) limit = fca_pkg::REG_PREDS;
      for (int k = 0; k < limit; k++) begin
        pcol = pred_sel[k][fca_pkg::SELECT_W-1:fca_pkg::CODE_W];
        if (pcol < fca_pkg::NUM_COLUMNS && pcol == col) begin
          if (empty || !test_passes(pred_sel[k][fca_pkg::CODE_W-1:0], val, pred_ref[k]))
            row_pass = 1'b0;
        end
      end
      if (col == agg_col) begin
        row_agg    = val;
        row_agg_ok = !empty;
      end
    end
    if (s_tlast) close_row();
  endtask

  task automatic write_reg();
    logic [fca_pkg::INDEX_W-1:0] offs;
    int                          k;
    if (cfg_index == fca_pkg::REG_AGG_COLUMN) begin
      agg_col = cfg_data[fca_pkg::COLUMN_W-1:0];
    end else if (cfg_index == fca_pkg::REG_PRED_COUNT) begin
      pred_cnt = cfg_data[fca_pkg::PCOUNT_W-1:0];
    end else if (cfg_index >= fca_pkg::REG_PRED0_SELECT) begin
      offs = cfg_index - fca_pkg::REG_PRED0_SELECT;
      k    = offs >> 1;
      if (k < fca_pkg::REG_PREDS) begin
        if (offs[0] == 1'b0) pred_sel[k] = cfg_data[fca_pkg::SELECT_W-1:0];
        else pred_ref[k] = cfg_data;
      end
    end
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_report();
    fca_pkg::result_t got;
    fca_pkg::result_t want;
    got = m_tdata[160:0];
    if (due_reports.size() == 0) begin
      err_count++;
      $display("%0t: report expected none actual max %0d min %0d avg %0d count %0d",
               $time, got.largest, got.smallest, got.avg_value, got.match_count);
      return;
    end
    want = due_reports.pop_front();
    report_field("largest", want.largest, got.largest);
    report_field("smallest", want.smallest, got.smallest);
    report_field("avg_value", want.avg_value, got.avg_value);
    report_field("match_count", want.match_count, got.match_count);
    report_field("no_match", want.no_match, got.no_match);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      agg_col  = fca_pkg::AGG_COLUMN_RESET;
      pred_cnt = '0;
      for (int k = 0; k < fca_pkg::REG_PREDS; k++) begin
        pred_sel[k] = '0;
        pred_ref[k] = '0;
      end
      open_row();
      clear_totals();
      due_reports.delete();
    end else begin
      if (m_tvalid && m_tready) check_report();
      if (cfg_wr_en) write_reg();
      if (s_tvalid && s_tready) take_cell();
    end
    reports_due <= due_reports.size();
  end

endmodule

@@ tb/sv/tb_filtered_column_aggregate_unit.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_filtered_column_aggregate_unit
// Drives table cells and end-of-table markers into the filtered column
// aggregate unit under changing filter setups, with random idling on both
// streams, and leaves prediction and comparison to the report checker.
// ---------------------------------------------------------------------------
module tb_filtered_column_aggregate_unit;

  localparam int ITEM_TARGET   = 1750;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 1500;

  localparam logic [fca_pkg::INDEX_W-1:0] REG_PRED_STRIDE = 3'd2;
  localparam logic [fca_pkg::CODE_W-1:0]  CMP_UNDEF       = 3'd6;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [fca_pkg::INDEX_W-1:0] cfg_index = '0;
  logic [fca_pkg::VALUE_W-1:0] cfg_data  = '0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [55:0]                 s_tdata   = '0;   // column[3:0], cell_value[51:4]
  logic [1:0]                  s_tuser   = '0;   // op[0], cell_empty[1]
  logic                        s_tlast   = 1'b0; // row_last
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [167:0]                m_tdata;          // largest[47:0], smallest[95:48],
                                                 // avg_value[143:96],
                                                 // match_count[159:144], no_match[160]
  int                          mismatches;
  int                          reports_due;

  // filter setup as last written
  logic [fca_pkg::COLUMN_W-1:0]       cur_agg;
  logic [fca_pkg::PCOUNT_W-1:0]       cur_cnt;
  logic [fca_pkg::SELECT_W-1:0]       cur_sel [fca_pkg::REG_PREDS];
  logic signed [fca_pkg::VALUE_W-1:0] cur_ref [fca_pkg::REG_PREDS];

  int items_sent = 0;
  int stall_req  = 0;
  bit burst_mode = 1'b0;

  filtered_column_aggregate_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  fca_report_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_filtered_column_aggregate_unit: done, errors");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [fca_pkg::VALUE_W-1:0] fixed(input int n);
    longint v;
    v = longint'(n) <<< 16;
    return v[fca_pkg::VALUE_W-1:0];
  endfunction

  function automatic logic [fca_pkg::VALUE_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[fca_pkg::VALUE_W-1:0];
  endfunction

  // lean toward the references so compares land on both sides
  function automatic logic [fca_pkg::VALUE_W-1:0] pick_value();
    int                          r;
    longint                      s;
    logic [fca_pkg::VALUE_W-1:0] refv;
    r    = $urandom_range(0, 99);
    refv = cur_ref[$urandom_range(0, fca_pkg::REG_PREDS - 1)];
    if (r < 20) return refv;
    if (r < 25) return refv + 1'b1;
    if (r < 30) return refv - 1'b1;
    if (r < 34) return fca_pkg::MAX48;
    if (r < 38) return fca_pkg::MIN48;
    if (r < 55) begin
      s = longint'($urandom_range(0, 2000)) - 1000;
      if (r < 45) s = s <<< 16;
      return s[fca_pkg::VALUE_W-1:0];
    end
    return rand48();
  endfunction

  task automatic send_item(input logic op, input logic [fca_pkg::COLUMN_W-1:0] col,
                           input logic [fca_pkg::VALUE_W-1:0] val, input logic empty,
                           input logic last);
    int gap;
    gap = burst_mode ? 0 : idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, val, col};
    s_tuser  <= {empty, op};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (op == fca_pkg::OP_END || col < fca_pkg::NUM_COLUMNS) items_sent++;
  endtask

  task automatic send_cell(input int col, input logic [fca_pkg::VALUE_W-1:0] val,
                           input logic empty, input logic last);
    send_item(fca_pkg::OP_CELL, col[fca_pkg::COLUMN_W-1:0], val, empty, last);
  endtask

  task automatic send_end();
    send_item(fca_pkg::OP_END, 4'($urandom_range(0, 15)), rand48(),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input logic [fca_pkg::INDEX_W-1:0] idx,
                           input logic [fca_pkg::VALUE_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_config();
    logic [fca_pkg::INDEX_W-1:0] idx;
    write_reg(fca_pkg::REG_AGG_COLUMN,
              {{(fca_pkg::VALUE_W-fca_pkg::COLUMN_W){1'b0}}, cur_agg});
    write_reg(fca_pkg::REG_PRED_COUNT,
              {{(fca_pkg::VALUE_W-fca_pkg::PCOUNT_W){1'b0}}, cur_cnt});
    idx = fca_pkg::REG_PRED0_SELECT;
    for (int k = 0; k < fca_pkg::REG_PREDS; k++) begin
      write_reg(idx, {{(fca_pkg::VALUE_W-fca_pkg::SELECT_W){1'b0}}, cur_sel[k]});
      write_reg(idx + 1'b1, cur_ref[k]);
      idx = idx + REG_PRED_STRIDE;
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // hold input, let every report come out and the back settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int r;
    cur_agg = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11))
                                           : 4'($urandom_range(12, 15));
    cur_cnt = 2'($urandom_range(0, 3));
    for (int k = 0; k < fca_pkg::REG_PREDS; k++) begin
      cur_sel[k][fca_pkg::SELECT_W-1:fca_pkg::CODE_W] =
        ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11))
                                     : 4'($urandom_range(12, 15));
      cur_sel[k][fca_pkg::CODE_W-1:0] = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 10) cur_ref[k] = fca_pkg::MAX48;
      else if (r < 20) cur_ref[k] = fca_pkg::MIN48;
      else if (r < 60) cur_ref[k] = fixed($urandom_range(0, 200) - 100);
      else cur_ref[k] = rand48();
    end
  endtask

  // one row in column order, with holes and repeats; an open row has no last mark
  task automatic send_row(input bit open_row);
    logic [fca_pkg::COLUMN_W-1:0] cols [$];
    int width;
    width = ($urandom_range(0, 1) == 1) ? fca_pkg::NUM_COLUMNS
                                        : $urandom_range(2, fca_pkg::NUM_COLUMNS);
    for (int c = 0; c < width; c++) begin
      if ($urandom_range(0, 99) < 15) continue;
      cols.push_back(c[fca_pkg::COLUMN_W-1:0]);
      if ($urandom_range(0, 99) < 5) cols.push_back(c[fca_pkg::COLUMN_W-1:0]);
    end
    if (cols.size() == 0) cols.push_back(cur_agg);
    foreach (cols[i])
      send_item(fca_pkg::OP_CELL, cols[i], pick_value(), ($urandom_range(0, 99) < 5),
                !open_row && (i == cols.size() - 1));
  endtask

  task automatic send_table();
    int rows;
    rows = $urandom_range(0, 6);
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3))
          send_item(fca_pkg::OP_CELL, 4'($urandom_range(0, 15)), rand48(),
                    1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 3));
      end else begin
        send_row(1'b0);
      end
    end
    if ($urandom_range(0, 99) < 6) send_row(1'b1);
    send_end();
  endtask

  // receiver stalls long while the sender keeps offering items
  task automatic fill_block();
    burst_mode = 1'b1;
    stall_req <= stall_req + 1;
    for (int n = 0; n < 15; n++) begin
      send_cell(cur_agg, pick_value(), 1'b0, 1'b1);
      send_end();
    end
    burst_mode = 1'b0;
  endtask

  initial begin : receiver
    int served;
    int hold;
    served = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_req != served) begin
        served = stall_req;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 99) < 5) begin
        m_tready <= 1'b1;
        repeat (200) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        hold = idle_gap();
        if (hold > 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_goal;
    phase = 0;
    cur_agg = fca_pkg::AGG_COLUMN_RESET;
    cur_cnt = '0;
    for (int k = 0; k < fca_pkg::REG_PREDS; k++) begin
      cur_sel[k] = '0;
      cur_ref[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: extremes and truncation of a negative average toward zero
    send_cell(9, fca_pkg::MAX48, 1'b0, 1'b1);
    send_cell(9, fca_pkg::MIN48, 1'b0, 1'b1);
    send_end();
    send_end();
    drain();

    // equality filter, undefined compare code, predicate on a column out of range
    cur_agg    = 4'd0;
    cur_cnt    = 2'd3;
    cur_sel[0] = {4'd1, fca_pkg::CMP_EQ};
    cur_ref[0] = fixed(5);
    cur_sel[1] = {4'd2, CMP_UNDEF};
    cur_ref[1] = fca_pkg::MAX48;
    cur_sel[2] = {4'd13, fca_pkg::CMP_LT};
    cur_ref[2] = fca_pkg::MIN48;
    program_config();
    send_cell(0, fixed(100), 1'b0, 1'b0);
    send_cell(1, fixed(5), 1'b0, 1'b0);
    send_cell(2, fixed(77), 1'b0, 1'b1);
    send_cell(0, fixed(200), 1'b0, 1'b0);
    send_cell(1, fixed(6), 1'b0, 1'b1);          // fails the equality
    send_cell(0, fixed(300), 1'b0, 1'b0);
    send_cell(1, fixed(5), 1'b0, 1'b0);
    send_cell(2, fixed(1), 1'b1, 1'b1);          // empty tested cell fails the row
    send_cell(0, fixed(400), 1'b0, 1'b0);
    send_cell(2, fixed(1), 1'b0, 1'b1);          // tested column absent
    send_cell(0, fixed(500), 1'b0, 1'b0);
    send_cell(14, rand48(), 1'b0, 1'b1);         // ignored cell still closes the row
    send_cell(0, fixed(-7), 1'b1, 1'b0);         // empty aggregate cell: skip row
    send_cell(1, fixed(5), 1'b0, 1'b1);
    send_cell(0, fixed(10), 1'b0, 1'b0);
    send_cell(0, fixed(20), 1'b0, 1'b0);         // last copy is aggregated
    send_cell(1, fixed(5), 1'b0, 1'b1);
    send_cell(0, fixed(999), 1'b0, 1'b0);        // open row dropped by end of table
    send_end();
    drain();

    // aggregate column out of range
    cur_agg = 4'd15;
    cur_cnt = 2'd0;
    program_config();
    send_cell(15, fixed(3), 1'b0, 1'b1);
    send_end();
    drain();

    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        cur_agg    = 4'd11;
        cur_cnt    = 2'd3;
        cur_sel[0] = {4'd0, fca_pkg::CMP_GE};
        cur_ref[0] = fca_pkg::MIN48;
        cur_sel[1] = {4'd11, fca_pkg::CMP_LE};
        cur_ref[1] = fca_pkg::MAX48;
        cur_sel[2] = {4'd5, fca_pkg::CMP_NE};
        cur_ref[2] = '0;
      end else begin
        random_config();
      end
      program_config();
      if (phase == 2) fill_block();
      burst_mode = ($urandom_range(0, 3) == 0);
      phase_goal = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_goal) send_table();
      burst_mode = 1'b0;
      drain();
      phase++;
    end

    if (mismatches == 0 && reports_due == 0) begin
      $display("tb_filtered_column_aggregate_unit: done, clean");
    end else begin
      $display("tb_filtered_column_aggregate_unit: done, errors");
    end
    $finish;
  end

endmodule
